### hw/rtl/sfc_pkg.sv
// ----------------------------------------------------------------------------
// sfc_pkg
// shared types and codes of the searchable fifo with counts
// ----------------------------------------------------------------------------
package sfc_pkg;

   typedef enum logic [3:0] {
      OP_PUSH        = 4'd0,
      OP_POP         = 4'd1,
      OP_FIND        = 4'd2,
      OP_REPLACE     = 4'd3,
      OP_LIST_ALL    = 4'd4,
      OP_LIST_EVEN   = 4'd5,
      OP_LIST_ODD    = 4'd6,
      OP_COUNT_EVEN  = 4'd7,
      OP_COUNT_PRIME = 4'd8
   } op_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_FULL    = 2'd1,
      ST_EMPTY   = 2'd2,
      ST_NOMATCH = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      FS_IDLE,
      FS_RD,
      FS_CHK,
      FS_PRIME,
      FS_LRD,
      FS_LCHK,
      FS_FIN
   } fsm_type;

   typedef enum logic [1:0] {
      PR_IDLE,
      PR_TEST,
      PR_DIV
   } prime_state_type;

   typedef struct packed {
      logic done;
      logic prime;
   } prime_rsp_type;

   // queue depth, tied to the position and tally field widths
   localparam int unsigned DEPTH      = 8;

   localparam int unsigned ITEM_BITS  = 16;
   localparam int unsigned POS_BITS   = 3;
   localparam int unsigned TALLY_BITS = 4;

endpackage

### hw/rtl/sfc_prime.sv
// ----------------------------------------------------------------------------
// sfc_prime
// iterative prime test: trial divisors with a bit-serial remainder
// ----------------------------------------------------------------------------
module sfc_prime #(
   parameter int unsigned VALUE_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [VALUE_BITS-1:0] value,
   output sfc_pkg::prime_rsp_type rsp
);
   import sfc_pkg::*;

   localparam int unsigned VB = VALUE_BITS;
   localparam int unsigned BW = $clog2(VB);

   prime_state_type state_ff, state_in;
   logic [VB-1:0] v_ff, v_in;
   logic [VB-1:0] d_ff, d_in;
   logic [VB+1:0] sq_ff, sq_in;
   logic [VB:0]   rem_ff, rem_in;
   logic [BW-1:0] bit_ff, bit_in;
   logic          done_ff, done_in;
   logic          prime_ff, prime_in;

   logic [VB:0] rem_shift;
   logic [VB:0] rem_sub;
   logic        sq_over;

   assign rem_shift = {rem_ff[VB-1:0], v_ff[bit_ff]};
   assign rem_sub   = (rem_shift >= {1'b0, d_ff}) ? rem_shift - {1'b0, d_ff} : rem_shift;
   assign sq_over   = sq_ff > (VB+2)'(v_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         PR_IDLE: begin
            if (start && value >= VB'(2)) state_in = PR_TEST;
         end
         PR_TEST: begin
            state_in = sq_over ? PR_IDLE : PR_DIV;
         end
         PR_DIV: begin
            if (bit_ff == '0) state_in = (rem_sub == '0) ? PR_IDLE : PR_TEST;
         end
         default: state_in = PR_IDLE;
      endcase
   end

   // datapath
   always_comb begin
      v_in     = v_ff;
      d_in     = d_ff;
      sq_in    = sq_ff;
      rem_in   = rem_ff;
      bit_in   = bit_ff;
      done_in  = 1'b0;
      prime_in = prime_ff;
      unique case (state_ff)
         PR_IDLE: begin
            if (start) begin
               v_in  = value;
               d_in  = VB'(2);
               sq_in = (VB+2)'(4);
               if (value < VB'(2)) begin
                  done_in  = 1'b1;
                  prime_in = 1'b0;
               end
            end
         end
         PR_TEST: begin
            rem_in = '0;
            bit_in = BW'(VB - 1);
            if (sq_over) begin
               done_in  = 1'b1;
               prime_in = 1'b1;
            end
         end
         PR_DIV: begin
            rem_in = rem_sub;
            bit_in = bit_ff - 1'b1;
            if (bit_ff == '0) begin
               if (rem_sub == '0) begin
                  done_in  = 1'b1;
                  prime_in = 1'b0;
               end else begin
                  d_in  = d_ff + 1'b1;
                  sq_in = sq_ff + (VB+2)'({d_ff, 1'b0}) + (VB+2)'(1);
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= PR_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      v_ff     <= v_in;
      d_ff     <= d_in;
      sq_ff    <= sq_in;
      rem_ff   <= rem_in;
      bit_ff   <= bit_in;
      prime_ff <= prime_in;
   end

   assign rsp.done  = done_ff;
   assign rsp.prime = prime_ff;

endmodule

### hw/rtl/searchable_fifo_with_counts.sv
// ----------------------------------------------------------------------------
// searchable_fifo_with_counts
// bounded fifo in a circular memory with find, replace, list and count
// ----------------------------------------------------------------------------
// push and empty-queue cases: after the input transfer the result goes through FS_FIN to the output register
// pop, find, replace, count even: each occupied entry walked passes a memory read
//   state (FS_RD) and a check state (FS_CHK), then the result goes through FS_FIN
// list: a counting pass (FS_RD, FS_CHK) then an output pass (FS_LRD, FS_LCHK) over the occupied entries
// count prime: each entry waits in FS_PRIME for the serial trial-division unit
// one input item is in work at a time; sync reset empties the queue, memory kept
module searchable_fifo_with_counts #(
   parameter int unsigned VALUE_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,  // op[3:0], value[19:4], new_value[35:20], zero pad
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,  // status[1:0], item[17:2], position[20:18],
                                   // tally[24:21], zero pad
   output logic        rsp_tlast
);
   import sfc_pkg::*;

   localparam int unsigned VB = VALUE_BITS;
   localparam int unsigned PW = $clog2(DEPTH);      // memory address bits
   localparam int unsigned OW = $clog2(DEPTH + 1);  // occupancy / index bits

   // circular address: base plus offset, wrapped at DEPTH
   function automatic logic [PW-1:0] wrap_addr(logic [PW-1:0] base, logic [OW-1:0] off);
      logic [OW:0] s;
      s = (OW+1)'(base) + (OW+1)'(off);
      if (s >= (OW+1)'(DEPTH)) s = s - (OW+1)'(DEPTH);
      return s[PW-1:0];
   endfunction

   function automatic logic pick(logic [3:0] op, logic [VB-1:0] d);
      logic r;
      r = 1'b1;
      if (op == OP_LIST_EVEN) r = ~d[0];
      if (op == OP_LIST_ODD)  r = d[0];
      return r;
   endfunction

   // control state
   fsm_type       state_ff, state_in;
   logic [PW-1:0] head_ff, head_in;
   logic [OW-1:0] occ_ff, occ_in;
   logic [OW-1:0] idx_ff, idx_in;
   logic [OW-1:0] cnt_ff, cnt_in;
   logic [OW-1:0] k_ff, k_in;
   logic          rsp_valid_ff, rsp_valid_in;

   // payload
   logic [3:0]     op_ff, op_in;
   logic [VB-1:0]  key_ff, key_in;
   logic [VB-1:0]  repl_ff, repl_in;
   status_type     res_status_ff, res_status_in;
   logic [15:0]    res_item_ff, res_item_in;
   logic [2:0]     res_pos_ff, res_pos_in;
   logic [3:0]     res_tally_ff, res_tally_in;
   logic [31:0]    rsp_data_ff, rsp_data_in;
   logic           rsp_last_ff, rsp_last_in;

   // memory
   logic [VB-1:0] mem [DEPTH];
   logic [VB-1:0] mem_q_ff;
   logic [PW-1:0] rd_addr;
   logic          wr_en;
   logic [PW-1:0] wr_addr;
   logic [VB-1:0] wr_data;

   // prime unit
   logic          prime_start;
   prime_rsp_type prime_rsp;

   logic           accept;
   logic           can_emit;
   logic           emit;
   status_type     em_status;
   logic [15:0]    em_item;
   logic [2:0]     em_pos;
   logic [3:0]     em_tally;
   logic           em_last;
   logic           last_idx;
   logic           d_pick;
   logic [OW-1:0]  cnt_list;

   assign req_tready = (state_ff == FS_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign can_emit   = !rsp_valid_ff || rsp_tready;
   assign rd_addr    = wrap_addr(head_ff, idx_ff);
   assign last_idx   = (idx_ff == occ_ff - 1'b1);
   assign d_pick     = pick(op_ff, mem_q_ff);
   assign cnt_list   = cnt_ff + OW'(d_pick);

   sfc_prime #(.VALUE_BITS(VB)) u_prime (
      .clock (clock),
      .reset (reset),
      .start (prime_start),
      .value (mem_q_ff),
      .rsp   (prime_rsp)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         FS_IDLE: begin
            if (accept) begin
               if (req_tdata[3:0] == OP_PUSH) state_in = FS_FIN;
               else if (req_tdata[3:0] > OP_COUNT_PRIME) state_in = FS_IDLE;
               else if (occ_ff == '0) state_in = FS_FIN;
               else state_in = FS_RD;
            end
         end
         FS_RD: state_in = FS_CHK;
         FS_CHK: begin
            priority case (op_ff)
               OP_POP: state_in = FS_FIN;
               OP_FIND, OP_REPLACE: begin
                  if (mem_q_ff == key_ff || last_idx) state_in = FS_FIN;
                  else state_in = FS_RD;
               end
               OP_LIST_ALL, OP_LIST_EVEN, OP_LIST_ODD: begin
                  if (!last_idx) state_in = FS_RD;
                  else state_in = (cnt_list == '0) ? FS_FIN : FS_LRD;
               end
               OP_COUNT_EVEN: state_in = last_idx ? FS_FIN : FS_RD;
               OP_COUNT_PRIME: state_in = FS_PRIME;
               default: state_in = FS_IDLE;
            endcase
         end
         FS_PRIME: begin
            if (prime_rsp.done) state_in = last_idx ? FS_FIN : FS_RD;
         end
         FS_LRD: state_in = FS_LCHK;
         FS_LCHK: begin
            if (!d_pick) state_in = FS_LRD;
            else if (can_emit) state_in = (k_ff + 1'b1 == cnt_ff) ? FS_IDLE : FS_LRD;
         end
         FS_FIN: begin
            if (can_emit) state_in = FS_IDLE;
         end
         default: state_in = FS_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      head_in       = head_ff;
      occ_in        = occ_ff;
      idx_in        = idx_ff;
      cnt_in        = cnt_ff;
      k_in          = k_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      repl_in       = repl_ff;
      res_status_in = res_status_ff;
      res_item_in   = res_item_ff;
      res_pos_in    = res_pos_ff;
      res_tally_in  = res_tally_ff;
      wr_en         = 1'b0;
      wr_addr       = rd_addr;
      wr_data       = repl_ff;
      prime_start   = 1'b0;
      emit          = 1'b0;
      em_status     = res_status_ff;
      em_item       = res_item_ff;
      em_pos        = res_pos_ff;
      em_tally      = res_tally_ff;
      em_last       = 1'b1;
      unique case (state_ff)
         FS_IDLE: begin
            if (accept) begin
               op_in         = req_tdata[3:0];
               key_in        = VB'(req_tdata[19:4]);
               repl_in       = VB'(req_tdata[35:20]);
               idx_in        = '0;
               cnt_in        = '0;
               k_in          = '0;
               res_status_in = ST_OK;
               res_item_in   = '0;
               res_pos_in    = '0;
               res_tally_in  = '0;
               if (req_tdata[3:0] == OP_PUSH) begin
                  if (occ_ff == OW'(DEPTH)) begin
                     res_status_in = ST_FULL;
                  end else begin
                     // write at the tail
                     wr_en   = 1'b1;
                     wr_addr = wrap_addr(head_ff, occ_ff);
                     wr_data = VB'(req_tdata[19:4]);
                     occ_in  = occ_ff + 1'b1;
                  end
               end else if (occ_ff == '0) begin
                  res_status_in = ST_EMPTY;
               end
            end
         end
         FS_RD: ;
         FS_CHK: begin
            priority case (op_ff)
               OP_POP: begin
                  res_item_in = ITEM_BITS'(mem_q_ff);
                  head_in     = wrap_addr(head_ff, OW'(1));
                  occ_in      = occ_ff - 1'b1;
               end
               OP_FIND, OP_REPLACE: begin
                  if (mem_q_ff == key_ff) begin
                     wr_en      = (op_ff == OP_REPLACE);
                     res_pos_in = POS_BITS'(idx_ff);
                  end else if (last_idx) begin
                     res_status_in = ST_NOMATCH;
                  end else begin
                     idx_in = idx_ff + 1'b1;
                  end
               end
               OP_LIST_ALL, OP_LIST_EVEN, OP_LIST_ODD: begin
                  cnt_in = cnt_list;
                  if (!last_idx) idx_in = idx_ff + 1'b1;
                  else if (cnt_list == '0) res_status_in = ST_NOMATCH;
                  else idx_in = '0;
               end
               OP_COUNT_EVEN: begin
                  cnt_in       = cnt_ff + OW'(!mem_q_ff[0]);
                  res_tally_in = TALLY_BITS'(cnt_ff + OW'(!mem_q_ff[0]));
                  if (!last_idx) idx_in = idx_ff + 1'b1;
               end
               OP_COUNT_PRIME: prime_start = 1'b1;
               default: ;
            endcase
         end
         FS_PRIME: begin
            if (prime_rsp.done) begin
               cnt_in       = cnt_ff + OW'(prime_rsp.prime);
               res_tally_in = TALLY_BITS'(cnt_ff + OW'(prime_rsp.prime));
               if (!last_idx) idx_in = idx_ff + 1'b1;
            end
         end
         FS_LRD: ;
         FS_LCHK: begin
            em_status = ST_OK;
            em_item   = ITEM_BITS'(mem_q_ff);
            em_pos    = '0;
            em_tally  = '0;
            em_last   = (k_ff + 1'b1 == cnt_ff);
            if (!d_pick) begin
               idx_in = idx_ff + 1'b1;
            end else if (can_emit) begin
               emit   = 1'b1;
               k_in   = k_ff + 1'b1;
               idx_in = idx_ff + 1'b1;
            end
         end
         FS_FIN: begin
            emit = can_emit;
         end
         default: ;
      endcase
   end

   // output register: a held result does not block the next input transfer
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {7'd0, em_tally, em_pos, em_item, em_status};
         rsp_last_in  = em_last;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      mem_q_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FS_IDLE;
         head_ff      <= '0;
         occ_ff       <= '0;
         idx_ff       <= '0;
         cnt_ff       <= '0;
         k_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         occ_ff       <= occ_in;
         idx_ff       <= idx_in;
         cnt_ff       <= cnt_in;
         k_ff         <= k_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff         <= op_in;
      key_ff        <= key_in;
      repl_ff       <= repl_in;
      res_status_ff <= res_status_in;
      res_item_ff   <= res_item_in;
      res_pos_ff    <= res_pos_in;
      res_tally_ff  <= res_tally_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   // occupancy never passes the depth
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= OW'(DEPTH))
      else $error("occupancy above depth");

   // a push into a non-full queue grows it by one
   a_push_grow: assert property (@(posedge clock) disable iff (reset)
      (accept && req_tdata[3:0] == OP_PUSH && occ_ff != OW'(DEPTH))
      |=> occ_ff == OW'($past(occ_ff) + 1'b1))
      else $error("push did not grow occupancy");

   // the prime unit reports only while a prime count waits on it
   a_prime_done: assert property (@(posedge clock) disable iff (reset)
      prime_rsp.done |-> state_ff == FS_PRIME)
      else $error("prime result outside prime wait");

   // a list result never reports more items than were counted
   a_list_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == FS_LCHK |-> k_ff < cnt_ff)
      else $error("list emitted past its count");

endmodule
